/* src/pbb_pkg.sv */
// shared types and constants of the page bitmap blitter
package pbb_pkg;

   localparam int ROW_DEPTH = 128;
   localparam int COL_BITS = 8;
   localparam int PAGE_BITS = 4;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_BITMAP_WIDTH  = 3'd2,
      CSR_BITMAP_HEIGHT = 3'd3,
      CSR_BLEND_MODE    = 3'd4,
      CSR_ALLOW_WRAP    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      BLEND_OPAQUE = 2'd0,
      BLEND_OR     = 2'd1,
      BLEND_AND    = 2'd2
   } blend_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_HEIGHT   = 2'd1,
      ERR_OVERFLOW = 2'd2
   } error_type;

   typedef struct packed {
      logic [6:0] origin_x;
      logic [5:0] origin_y;
      logic [7:0] bitmap_width;
      logic [6:0] bitmap_height;
      logic [1:0] blend_mode;
      logic       allow_wrap;
   } cfg_type;

   // one framebuffer access, or one error report
   typedef struct packed {
      logic [1:0]           error_code;
      logic                 write;
      logic [PAGE_BITS-1:0] page;
      logic [COL_BITS-1:0]  col;
      logic [7:0]           data;
      logic [7:0]           keep;
      logic                 last_result;
      logic                 bitmap_done;
   } op_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

/* src/page_bitmap_blit.sv */
// top level of the page bitmap blitter
//
// Bitmap column bytes enter on the req_ channel in row-major page order, one
// per transfer (valid high, stall low). Each byte yields one framebuffer write
// on the rsp_ channel, two on the last page row when origin_y is not a
// multiple of 8; a bad height or a forbidden overflow yields one error result.
// The csr_ port writes one register per cycle with csr_write; any write of a
// known index restarts the bitmap at its first byte. Write it only when idle.
// A byte waits in the front-end f1 registers until its ops are pushed, then passes
// a two-entry queue to the back end, which does one framebuffer read-modify-write
// per cycle while rsp_stall is low, on a read port and a write port with
// write-to-read forwarding. Sustained: one byte per cycle while rsp_stall is low;
// a byte with two writes pushes them in turn. Each op passes f1, the queue, b1
// and the output register that drives rsp_valid. After reset the framebuffer,
// SCREEN_COLUMNS * SCREEN_ROWS / 8 bytes (1024 by default), is cleared one byte a
// cycle; req_stall is high during that pass. A stalled result holds in the output
// register; up to four more ops wait behind it (one in the back end, two in the
// queue, one in the front end) before req_stall rises.
module page_bitmap_blit #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_bitmap_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_screen_half,
   output logic [2:0] rsp_page_index,
   output logic [5:0] rsp_column_index,
   output logic [7:0] rsp_write_data,
   output logic       rsp_write_valid,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_result,
   output logic       rsp_bitmap_done
);
   import pbb_pkg::*;

   cfg_type         cfg_ff;
   logic            restart;
   logic            push_valid;
   logic            push_full;
   op_type          push_op;
   logic            pop;
   logic            pop_valid;
   op_type          pop_op;
   back_status_type status;

   always_comb begin
      case (csr_index)
         CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_BITMAP_WIDTH,
         CSR_BITMAP_HEIGHT, CSR_BLEND_MODE, CSR_ALLOW_WRAP: restart = csr_write;
         default: restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= 7'd0;
         cfg_ff.origin_y <= 6'd0;
         cfg_ff.bitmap_width <= 8'd8;
         cfg_ff.bitmap_height <= 7'd8;
         cfg_ff.blend_mode <= BLEND_OPAQUE;
         cfg_ff.allow_wrap <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ORIGIN_X:      cfg_ff.origin_x <= csr_data[6:0];
            CSR_ORIGIN_Y:      cfg_ff.origin_y <= csr_data[5:0];
            CSR_BITMAP_WIDTH:  cfg_ff.bitmap_width <= csr_data;
            CSR_BITMAP_HEIGHT: cfg_ff.bitmap_height <= csr_data[6:0];
            CSR_BLEND_MODE:    cfg_ff.blend_mode <= csr_data[1:0];
            CSR_ALLOW_WRAP:    cfg_ff.allow_wrap <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   pbb_front #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .restart(restart),
      .hold(status.clearing),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_bitmap_byte(req_bitmap_byte),
      .push_valid(push_valid),
      .push_full(push_full),
      .push_op(push_op)
   );

   pbb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_full(push_full),
      .push_op(push_op),
      .pop(pop),
      .pop_valid(pop_valid),
      .pop_op(pop_op)
   );

   pbb_back #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .blend_mode(cfg_ff.blend_mode),
      .pop_valid(pop_valid),
      .pop(pop),
      .pop_op(pop_op),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_screen_half(rsp_screen_half),
      .rsp_page_index(rsp_page_index),
      .rsp_column_index(rsp_column_index),
      .rsp_write_data(rsp_write_data),
      .rsp_write_valid(rsp_write_valid),
      .rsp_error_code(rsp_error_code),
      .rsp_last_result(rsp_last_result),
      .rsp_bitmap_done(rsp_bitmap_done)
   );

   // nothing can be in flight while the framebuffer is still being cleared
   assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_valid && !status.busy && !pop_valid)
      else $error("result or op present during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> !rsp_write_valid && rsp_last_result
         && !rsp_bitmap_done)
      else $error("error result carries a write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bitmap_done |-> rsp_last_result && rsp_write_valid)
      else $error("bitmap done on a result that is not the last of its byte");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> status.busy)
      else $error("popped op lost in back end");

endmodule

/* src/pbb_front.sv */
// front end: accepts bitmap bytes, tracks position, builds framebuffer ops
module pbb_front #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  pbb_pkg::cfg_type cfg,
   input  logic             restart,
   input  logic             hold,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_bitmap_byte,
   output logic             push_valid,
   input  logic             push_full,
   output pbb_pkg::op_type  push_op
);
   import pbb_pkg::*;

   localparam int PAGE_COUNT = SCREEN_ROWS / 8;
   localparam logic [9:0] COLS_LIMIT = 10'(SCREEN_COLUMNS);
   localparam logic [9:0] ROWS_LIMIT = 10'(SCREEN_ROWS);
   localparam logic [8:0] COLS_END = 9'(SCREEN_COLUMNS);
   localparam logic [4:0] PAGES_END = 5'(PAGE_COUNT);
   localparam logic [7:0] WIDTH_MAX = 8'(ROW_DEPTH);

   function automatic logic [4:0] page_wrap(input logic [4:0] value);
      logic [4:0] m;
      m = value;
      for (int i = 0; i < 8; i++) begin
         if (m >= PAGES_END) begin
            m = m - PAGES_END;
         end
      end
      return m;
   endfunction

   logic [7:0] row_mem [ROW_DEPTH];

   logic [3:0] row_ff;
   logic [6:0] col_count_ff;
   logic [7:0] col_ff;
   logic [3:0] page_ff;

   logic       f1_valid_ff;
   logic       f1_phase_ff;
   logic [1:0] f1_err_ff;
   logic [7:0] f1_byte_ff;
   logic [3:0] f1_page_ff;
   logic [7:0] f1_col_ff;
   logic [2:0] f1_shift_ff;
   logic       f1_first_ff;
   logic       f1_extra_ff;
   logic       f1_finish_ff;
   logic [7:0] row_rd_ff;

   logic [7:0] width_eff;
   logic [7:0] width_last;
   logic [3:0] rows;
   logic [1:0] err;
   logic [9:0] x_end;
   logic [9:0] y_end;
   logic [7:0] ox_wrapped;
   logic [3:0] page_base;
   logic [7:0] col_cur;
   logic [8:0] col_inc;
   logic [7:0] col_next;
   logic [3:0] page_cur;
   logic [4:0] page_inc;
   logic [3:0] page_next;
   logic       col_last;
   logic       row_last;
   logic       accept;
   logic       f1_push;
   logic       f1_leave;

   logic [15:0] byte_up;
   logic [15:0] keep_up;
   logic [3:0]  shift_back;
   logic [7:0]  byte_down;
   logic [7:0]  row_down;
   logic [7:0]  data0;
   logic [7:0]  keep0;
   logic [4:0]  f1_page_inc;
   logic [3:0]  f1_page_next;

   always_comb begin
      if (cfg.bitmap_width == 8'd0) begin
         width_eff = 8'd1;
      end else if (cfg.bitmap_width > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = cfg.bitmap_width;
      end
      width_last = width_eff - 8'd1;
      rows = cfg.bitmap_height[6:3];
      x_end = {3'd0, cfg.origin_x} + {2'd0, width_eff};
      y_end = {4'd0, cfg.origin_y} + {3'd0, cfg.bitmap_height};
      if (cfg.bitmap_height == 7'd0 || cfg.bitmap_height[2:0] != 3'd0) begin
         err = ERR_HEIGHT;
      end else if (!cfg.allow_wrap && (x_end > COLS_LIMIT || y_end > ROWS_LIMIT)) begin
         err = ERR_OVERFLOW;
      end else begin
         err = ERR_NONE;
      end

      // origin_x is below twice the narrowest screen
      if ({2'd0, cfg.origin_x} >= COLS_END) begin
         ox_wrapped = 8'({2'd0, cfg.origin_x} - COLS_END);
      end else begin
         ox_wrapped = {1'b0, cfg.origin_x};
      end
      page_base = 4'(page_wrap({2'd0, cfg.origin_y[5:3]}));

      col_cur = (col_count_ff == 7'd0) ? ox_wrapped : col_ff;
      col_inc = {1'b0, col_cur} + 9'd1;
      col_next = (col_inc == COLS_END) ? 8'd0 : col_inc[7:0];
      page_cur = (row_ff == 4'd0) ? page_base : page_ff;
      page_inc = {1'b0, page_cur} + 5'd1;
      page_next = (page_inc == PAGES_END) ? 4'd0 : page_inc[3:0];

      col_last = ({1'b0, col_count_ff} == width_last);
      row_last = (row_ff == rows - 4'd1);
   end

   assign f1_push = f1_valid_ff && !push_full;
   assign f1_leave = f1_push && (f1_err_ff != ERR_NONE || !f1_extra_ff || f1_phase_ff);
   assign req_stall = hold || (f1_valid_ff && !f1_leave);
   assign accept = req_valid && !req_stall;
   assign push_valid = f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f1_phase_ff <= 1'b0;
         row_ff <= 4'd0;
         col_count_ff <= 7'd0;
      end else begin
         if (accept) begin
            f1_valid_ff <= 1'b1;
            f1_phase_ff <= 1'b0;
         end else if (f1_leave) begin
            f1_valid_ff <= 1'b0;
         end else if (f1_push) begin
            f1_phase_ff <= 1'b1;
         end

         if (restart) begin
            row_ff <= 4'd0;
            col_count_ff <= 7'd0;
         end else if (accept && err == ERR_NONE) begin
            if (col_last) begin
               col_count_ff <= 7'd0;
               row_ff <= row_last ? 4'd0 : row_ff + 4'd1;
            end else begin
               col_count_ff <= col_count_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && err == ERR_NONE) begin
         col_ff <= col_next;
         page_ff <= col_last ? page_next : page_cur;
         row_mem[col_count_ff] <= req_bitmap_byte;
      end
      if (accept) begin
         // reads the byte of the page row above before this transfer replaces it
         row_rd_ff <= row_mem[col_count_ff];
         f1_err_ff <= err;
         f1_byte_ff <= req_bitmap_byte;
         f1_page_ff <= page_cur;
         f1_col_ff <= col_cur;
         f1_shift_ff <= cfg.origin_y[2:0];
         f1_first_ff <= (row_ff == 4'd0);
         f1_extra_ff <= row_last && (cfg.origin_y[2:0] != 3'd0);
         f1_finish_ff <= row_last && col_last;
      end
   end

   always_comb begin
      byte_up = {8'd0, f1_byte_ff} << f1_shift_ff;
      keep_up = 16'h00FF << f1_shift_ff;
      shift_back = 4'd8 - {1'b0, f1_shift_ff};
      byte_down = f1_byte_ff >> shift_back;
      row_down = row_rd_ff >> shift_back;
      f1_page_inc = {1'b0, f1_page_ff} + 5'd1;
      f1_page_next = (f1_page_inc == PAGES_END) ? 4'd0 : f1_page_inc[3:0];

      if (f1_shift_ff == 3'd0) begin
         data0 = f1_byte_ff;
         keep0 = 8'h00;
      end else if (f1_first_ff) begin
         data0 = byte_up[7:0];
         keep0 = 8'hFF >> shift_back;
      end else begin
         data0 = byte_up[7:0] | row_down;
         keep0 = 8'h00;
      end

      push_op = '0;
      push_op.error_code = f1_err_ff;
      if (f1_err_ff != ERR_NONE) begin
         push_op.last_result = 1'b1;
      end else if (!f1_phase_ff) begin
         push_op.write = 1'b1;
         push_op.page = f1_page_ff;
         push_op.col = f1_col_ff;
         push_op.data = data0;
         push_op.keep = keep0;
         push_op.last_result = !f1_extra_ff;
         push_op.bitmap_done = !f1_extra_ff && f1_finish_ff;
      end else begin
         // extra bottom page below the last data row
         push_op.write = 1'b1;
         push_op.page = f1_page_next;
         push_op.col = f1_col_ff;
         push_op.data = byte_down;
         push_op.keep = keep_up[7:0];
         push_op.last_result = 1'b1;
         push_op.bitmap_done = f1_finish_ff;
      end
   end

endmodule

/* src/pbb_queue.sv */
// two-entry op queue between front and back end
module pbb_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_full,
   input  pbb_pkg::op_type push_op,
   input  logic            pop,
   output logic            pop_valid,
   output pbb_pkg::op_type pop_op
);
   import pbb_pkg::*;

   op_type     entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign push_full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_op = entry_ff[rd_ptr_ff];
   assign push = push_valid && !push_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

/* src/pbb_back.sv */
// back end: framebuffer read-modify-write, clearing pass and result register
module pbb_back #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               blend_mode,
   input  logic                     pop_valid,
   output logic                     pop,
   input  pbb_pkg::op_type          pop_op,
   output pbb_pkg::back_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_screen_half,
   output logic [2:0]               rsp_page_index,
   output logic [5:0]               rsp_column_index,
   output logic [7:0]               rsp_write_data,
   output logic                     rsp_write_valid,
   output logic [1:0]               rsp_error_code,
   output logic                     rsp_last_result,
   output logic                     rsp_bitmap_done
);
   import pbb_pkg::*;

   localparam int DEPTH = SCREEN_COLUMNS * (SCREEN_ROWS / 8);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [8:0] HALF = 9'(SCREEN_COLUMNS / 2);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] addr_of(input op_type op);
      return ADDR_W'(int'(op.page) * SCREEN_COLUMNS + int'(op.col));
   endfunction

   logic [7:0] frame_mem [DEPTH];

   logic              clearing_ff;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic              b1_valid_ff;
   op_type            b1_op_ff;
   logic [7:0]        rd_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;

   logic              rsp_valid_ff;
   logic              rsp_half_ff;
   logic [2:0]        rsp_page_ff;
   logic [5:0]        rsp_col_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_wv_ff;
   logic [1:0]        rsp_err_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic              out_free;
   logic              fire;
   logic              advance;
   logic              wen;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        old_byte;
   logic [7:0]        new_byte;
   logic [8:0]        col_wide;
   logic              half;
   logic [8:0]        col_in_half;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire = b1_valid_ff && out_free;
   assign advance = !b1_valid_ff || out_free;
   assign pop = advance && pop_valid && !clearing_ff;
   assign waddr = addr_of(b1_op_ff);
   assign raddr = addr_of(pop_op);
   assign wen = fire && b1_op_ff.write;

   always_comb begin
      old_byte = fwd_ff ? fwd_data_ff : rd_ff;
      case (blend_mode)
         BLEND_OR:  new_byte = old_byte | b1_op_ff.data;
         BLEND_AND: new_byte = old_byte & (b1_op_ff.data | b1_op_ff.keep);
         default:   new_byte = (old_byte & b1_op_ff.keep) | b1_op_ff.data;
      endcase
      col_wide = {1'b0, b1_op_ff.col};
      half = (col_wide >= HALF);
      col_in_half = half ? col_wide - HALF : col_wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clear_addr_ff <= '0;
         b1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         if (advance) begin
            b1_valid_ff <= pop;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         frame_mem[clear_addr_ff] <= 8'h00;
      end else if (wen) begin
         frame_mem[waddr] <= new_byte;
      end
      if (pop) begin
         rd_ff <= frame_mem[raddr];
         // the write at this edge is not yet in the registered read
         fwd_ff <= wen && (waddr == raddr);
         fwd_data_ff <= new_byte;
         b1_op_ff <= pop_op;
      end
      if (fire) begin
         rsp_half_ff <= b1_op_ff.write && half;
         rsp_page_ff <= b1_op_ff.page[2:0];
         rsp_col_ff <= col_in_half[5:0];
         rsp_data_ff <= b1_op_ff.write ? new_byte : 8'h00;
         rsp_wv_ff <= b1_op_ff.write;
         rsp_err_ff <= b1_op_ff.error_code;
         rsp_last_ff <= b1_op_ff.last_result;
         rsp_done_ff <= b1_op_ff.bitmap_done;
      end
   end

   assign status.clearing = clearing_ff;
   assign status.busy = b1_valid_ff || rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_screen_half = rsp_half_ff;
   assign rsp_page_index = rsp_page_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_write_data = rsp_data_ff;
   assign rsp_write_valid = rsp_wv_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_bitmap_done = rsp_done_ff;

endmodule
